// File: src/bsb_pkg.sv
// Shared types and constants for the bitmap stream blitter.
package bsb_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SIDE_W     = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned COORD_W    = 13;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Byte positions inside a pixel
  localparam logic [PHASE_W-1:0] PHASE_LAST_BGR  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_LAST_BGRA = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_DEST_X       = 3'd2,
    CFG_DEST_Y       = 3'd3,
    CFG_PIXEL_FORMAT = 3'd4,
    CFG_TRANSP_EN    = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    FMT_BGR24  = 1'b0,
    FMT_BGRA32 = 1'b1
  } pixel_fmt_e;

  typedef struct packed {
    logic [SIDE_W-1:0] frame_width;
    logic [SIDE_W-1:0] frame_height;
    logic [POS_W-1:0]  dest_x;
    logic [POS_W-1:0]  dest_y;
    pixel_fmt_e        pixel_format;
    logic              transparent_enable;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
    logic [COLOR_W-1:0] color;
    logic               draw;
    logic               last;
  } result_t;

endpackage

// File: src/bsb_unpack.sv
// Byte-to-pixel assembly, row/column tracking and coordinate generation.
module bsb_unpack import bsb_pkg::*; #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [BYTE_W-1:0] pixel_byte_i,
  input  cfg_t              cfg_i,
  output logic              res_valid_o,
  output result_t           res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SIDE);
  localparam int unsigned CMP_W = ((CNT_W > SIDE_W) ? CNT_W : SIDE_W) + 1;

  logic [CNT_W-1:0]   col_q, col_d, row_q, row_d;
  logic [PHASE_W-1:0] phase_q, phase_d, pad_q, pad_d;
  logic [COLOR_W-1:0] part_q, part_d;

  logic [SIDE_W-1:0]  w_side, h_side;
  logic [PHASE_W-1:0] final_phase;
  logic [CMP_W-1:0]   col_nxt, row_nxt;
  logic               row_end, img_end;
  logic [COLOR_W-1:0] color;
  logic               opaque;

  // Clamp sides into 1..MAX_SIDE
  always_comb begin
    w_side = cfg_i.frame_width;
    if (cfg_i.frame_width == '0) begin
      w_side = SIDE_W'(1);
    end else if (32'(cfg_i.frame_width) > MAX_SIDE) begin
      w_side = SIDE_W'(MAX_SIDE);
    end
    h_side = cfg_i.frame_height;
    if (cfg_i.frame_height == '0) begin
      h_side = SIDE_W'(1);
    end else if (32'(cfg_i.frame_height) > MAX_SIDE) begin
      h_side = SIDE_W'(MAX_SIDE);
    end
  end

  assign final_phase = (cfg_i.pixel_format == FMT_BGRA32) ? PHASE_LAST_BGRA : PHASE_LAST_BGR;
  assign col_nxt     = CMP_W'(col_q) + CMP_W'(1);
  assign row_nxt     = CMP_W'(row_q) + CMP_W'(1);
  assign row_end     = (col_nxt >= CMP_W'(w_side));
  assign img_end     = row_end && (row_nxt >= CMP_W'(h_side));

  always_comb begin
    if (cfg_i.pixel_format == FMT_BGRA32) begin
      color  = part_q;
      opaque = (pixel_byte_i != '0);
    end else begin
      color  = {pixel_byte_i, part_q[15:0]};
      opaque = (color != '0);
    end
  end

  always_comb begin
    res_o.screen_x = COORD_W'(cfg_i.dest_x) + COORD_W'(col_q);
    res_o.screen_y = COORD_W'(cfg_i.dest_y) + COORD_W'(h_side) - COORD_W'(1)
                     - COORD_W'(row_q);
    res_o.color    = color;
    res_o.draw     = !(cfg_i.transparent_enable && !opaque);
    res_o.last     = img_end;
  end

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    phase_d     = phase_q;
    pad_d       = pad_q;
    part_d      = part_q;
    res_valid_o = 1'b0;
    if (fire_i) begin
      if (pad_q != '0) begin
        // drop a row pad byte
        pad_d = pad_q - PHASE_W'(1);
      end else if (phase_q < final_phase) begin
        if (phase_q != PHASE_LAST_BGRA) begin
          part_d = part_q | (COLOR_W'(pixel_byte_i) << {phase_q, 3'b000});
        end
        phase_d = phase_q + PHASE_W'(1);
      end else begin
        res_valid_o = 1'b1;
        phase_d     = '0;
        part_d      = '0;
        if (row_end) begin
          col_d = '0;
          row_d = img_end ? '0 : CNT_W'(row_nxt);
          pad_d = (cfg_i.pixel_format == FMT_BGRA32) ? '0 : w_side[PHASE_W-1:0];
        end else begin
          col_d = CNT_W'(col_nxt);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= '0;
      pad_q   <= '0;
      part_q  <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
      pad_q   <= pad_d;
      part_q  <= part_d;
    end
  end

endmodule

// File: src/bsb_out_buf.sv
// Output register with a skid slot for result requests.
module bsb_out_buf import bsb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic    load_out, load_skid, from_skid;
  result_t out_q, skid_q;

  always_comb begin
    out_v_d   = out_v_q;
    skid_v_d  = skid_v_q;
    load_out  = 1'b0;
    load_skid = 1'b0;
    from_skid = 1'b0;
    if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        from_skid = 1'b1;
        load_out  = 1'b1;
        out_v_d   = 1'b1;
        skid_v_d  = 1'b0;
      end else if (push_i) begin
        load_out = 1'b1;
        out_v_d  = 1'b1;
      end else begin
        out_v_d = 1'b0;
      end
    end else if (push_i) begin
      load_skid = 1'b1;
      skid_v_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= from_skid ? skid_q : push_data_i;
    end
    if (load_skid) begin
      skid_q <= push_data_i;
    end
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// File: src/bitmap_stream_blitter_core.sv
// Top level of the bitmap stream blitter: config registers, unpacker, output buffer.
//
// Program the image through the write port (cfg_we_i, cfg_idx_i, cfg_data_i):
// width, height, destination corner, pixel format and transparency enable.
// Write config only while the block is idle.
// Feed the pixel data bytes of a bottom-up bitmap on the input channel, one
// request per byte (in_valid_i / in_stall_o). Each third byte (24-bit BGR) or
// fourth byte (32-bit BGRA) completes a pixel and produces one result request
// on the output channel (out_valid_o / out_stall_i) carrying the flipped
// screen coordinate, packed color, draw flag and last-pixel flag. In 24-bit
// mode the row pad bytes (width mod 4) are consumed without a result.
// Timing: one byte is accepted per cycle while in_stall_o is low; a completing
// byte's result is registered into the output register, or into the skid slot
// while the receiver stalls.
// Reset: clears counters and output valid; width and height read 1, others 0.
// Backpressure: while the receiver stalls, the result holds in the output
// register and one more result parks in a skid slot; in_stall_o rises only
// when that slot is taken, so byte intake continues as long as possible.
module bitmap_stream_blitter_core import bsb_pkg::*; #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // byte input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [BYTE_W-1:0]     pixel_byte_i,
  // pixel result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_W-1:0]    screen_x_o,
  output logic [COORD_W-1:0]    screen_y_o,
  output logic [COLOR_W-1:0]    color_o,
  output logic                  draw_o,
  output logic                  last_o
);

  cfg_t    cfg_q;
  logic    in_fire;
  logic    res_valid;
  logic    buf_full;
  result_t res, out_res;

  // Decode register writes; drop writes past the register list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width        <= SIDE_W'(1);
      cfg_q.frame_height       <= SIDE_W'(1);
      cfg_q.dest_x             <= '0;
      cfg_q.dest_y             <= '0;
      cfg_q.pixel_format       <= FMT_BGR24;
      cfg_q.transparent_enable <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  cfg_q.frame_width        <= cfg_data_i[SIDE_W-1:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height       <= cfg_data_i[SIDE_W-1:0];
        CFG_DEST_X:       cfg_q.dest_x             <= cfg_data_i[POS_W-1:0];
        CFG_DEST_Y:       cfg_q.dest_y             <= cfg_data_i[POS_W-1:0];
        CFG_PIXEL_FORMAT: cfg_q.pixel_format       <= pixel_fmt_e'(cfg_data_i[0]);
        CFG_TRANSP_EN:    cfg_q.transparent_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Hold off input only when the skid slot is occupied.
  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i && !buf_full;

  bsb_unpack #(
    .MAX_SIDE (MAX_SIDE)
  ) u_unpack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .pixel_byte_i (pixel_byte_i),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  bsb_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign screen_x_o = out_res.screen_x;
  assign screen_y_o = out_res.screen_y;
  assign color_o    = out_res.color;
  assign draw_o     = out_res.draw;
  assign last_o     = out_res.last;

endmodule

// File: src/bsb_checker.sv
// Port-level checks for the bitmap stream blitter, bound to the top level.
module bsb_checker import bsb_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [COORD_W-1:0]    screen_x_o,
  input logic [COORD_W-1:0]    screen_y_o,
  input logic [COLOR_W-1:0]    color_o,
  input logic                  draw_o,
  input logic                  last_o
);

  localparam int unsigned CREDIT_W = 16;

  logic                in_fire, out_fire;
  logic [CREDIT_W-1:0] credit_q;
  logic [CREDIT_W:0]   credit_sum;
  logic                sat_q;

  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_o && !out_stall_i;
  assign credit_sum = {1'b0, credit_q} + (CREDIT_W + 1)'(in_fire);

  // Track bytes taken versus three bytes owed per delivered pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      sat_q    <= 1'b0;
    end else if (credit_sum[CREDIT_W]) begin
      sat_q <= 1'b1;
    end else if (out_fire) begin
      credit_q <= (credit_sum >= (CREDIT_W + 1)'(3)) ?
                  CREDIT_W'(credit_sum - (CREDIT_W + 1)'(3)) : '0;
    end else begin
      credit_q <= CREDIT_W'(credit_sum);
    end
  end

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable({screen_x_o, screen_y_o, color_o, draw_o, last_o}))
    else $error("result changed while stalled");

  a_bytes_per_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !sat_q |-> credit_q >= CREDIT_W'(3))
    else $error("pixel delivered with fewer than three bytes taken");

endmodule

bind bitmap_stream_blitter_core bsb_checker u_bsb_checker (.*);

// File: test/tb_bitmap_stream_blitter_core.sv
// Self-checking testbench for bitmap_stream_blitter_core: byte stream in, pixel results checked.
`timescale 1ns / 100ps

module tb_bitmap_stream_blitter_core;
  import bsb_pkg::*;

  localparam int unsigned SIDE_LIMIT  = 4096;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_WAIT   = 4;     // output register plus skid slot
  localparam int unsigned BYTE_BUDGET = 550;

  // Indexes past the register list; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // Tracks the blitter state, predicts one pixel per completing byte and
  // holds the pixels still owed by the block.
  class blit_scoreboard;
    cfg_t              cfg;
    logic [11:0]       col_cnt;
    logic [11:0]       row_cnt;
    logic [1:0]        phase;
    logic [1:0]        pad_left;
    logic [23:0]       gathered;
    result_t           pixels_due[$];
    int                n_checked;
    int                n_hidden;
    int                n_last;
    int                n_fail;

    function new();
      cfg.frame_width        = 13'd1;
      cfg.frame_height       = 13'd1;
      cfg.dest_x             = '0;
      cfg.dest_y             = '0;
      cfg.pixel_format       = FMT_BGR24;
      cfg.transparent_enable = 1'b0;
      col_cnt   = '0;
      row_cnt   = '0;
      phase     = '0;
      pad_left  = '0;
      gathered  = '0;
      n_checked = 0;
      n_hidden  = 0;
      n_last    = 0;
      n_fail    = 0;
    endfunction

    static function int unsigned side_of(logic [SIDE_W-1:0] v);
      if (v == 0) return 1;
      if (v > SIDE_LIMIT) return SIDE_LIMIT;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FRAME_WIDTH:  cfg.frame_width        = val;
        CFG_FRAME_HEIGHT: cfg.frame_height       = val;
        CFG_DEST_X:       cfg.dest_x             = val[POS_W-1:0];
        CFG_DEST_Y:       cfg.dest_y             = val[POS_W-1:0];
        CFG_PIXEL_FORMAT: cfg.pixel_format       = pixel_fmt_e'(val[0]);
        CFG_TRANSP_EN:    cfg.transparent_enable = val[0];
        default: ;
      endcase
    endfunction

    // Advance the unpacker by one accepted byte; queue a pixel if it completes one.
    function void note_byte(logic [7:0] b);
      int unsigned w;
      int unsigned h;
      int unsigned sx;
      int unsigned sy;
      logic [1:0]  last_ph;
      logic [23:0] color;
      bit          opaque;
      bit          row_end;
      bit          img_end;
      result_t     px;
      w = side_of(cfg.frame_width);
      h = side_of(cfg.frame_height);
      last_ph = (cfg.pixel_format == FMT_BGRA32) ? PHASE_LAST_BGRA : PHASE_LAST_BGR;
      if (pad_left != 0) begin
        pad_left = pad_left - 1'b1;
        return;
      end
      if (phase < last_ph) begin
        gathered = gathered | (24'(b) << (8 * phase));
        phase = phase + 1'b1;
        return;
      end
      if (cfg.pixel_format == FMT_BGRA32) begin
        color  = gathered;
        opaque = (b != 0);
      end else begin
        color  = {b, gathered[15:0]};
        opaque = (color != 0);
      end
      row_end = (32'(col_cnt) + 1 >= w);
      img_end = row_end && (32'(row_cnt) + 1 >= h);
      sx = 32'(cfg.dest_x) + 32'(col_cnt);
      sy = 32'(cfg.dest_y) + h - 1 - 32'(row_cnt);
      px.screen_x = sx[COORD_W-1:0];
      px.screen_y = sy[COORD_W-1:0];
      px.color    = color;
      px.draw     = !(cfg.transparent_enable && !opaque);
      px.last     = img_end;
      pixels_due.push_back(px);
      phase    = '0;
      gathered = '0;
      if (row_end) begin
        col_cnt  = '0;
        row_cnt  = img_end ? 12'd0 : row_cnt + 1'b1;
        pad_left = (cfg.pixel_format == FMT_BGRA32) ? 2'd0 : 2'(w & 3);
      end else begin
        col_cnt = col_cnt + 1'b1;
      end
    endfunction

    function void check_pixel(result_t got);
      result_t want;
      if (pixels_due.size() == 0) begin
        $error("pixel with none expected: x=%0d y=%0d color=%06h",
               got.screen_x, got.screen_y, got.color);
        n_fail++;
        return;
      end
      want = pixels_due.pop_front();
      n_checked++;
      if (!want.draw) n_hidden++;
      if (want.last) n_last++;
      if (got.screen_x !== want.screen_x) begin
        $error("screen_x: expected %0d, got %0d", want.screen_x, got.screen_x);
        n_fail++;
      end
      if (got.screen_y !== want.screen_y) begin
        $error("screen_y: expected %0d, got %0d", want.screen_y, got.screen_y);
        n_fail++;
      end
      if (got.color !== want.color) begin
        $error("color: expected %06h, got %06h", want.color, got.color);
        n_fail++;
      end
      if (got.draw !== want.draw) begin
        $error("draw: expected %0b, got %0b", want.draw, got.draw);
        n_fail++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        n_fail++;
      end
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     pixel_byte = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [COORD_W-1:0]    screen_x;
  logic [COORD_W-1:0]    screen_y;
  logic [COLOR_W-1:0]    color;
  logic                  draw;
  logic                  last;

  blit_scoreboard sb = new();

  int unsigned cycle_cnt    = 0;
  int unsigned bytes_sent   = 0;
  int unsigned settings     = 0;
  int unsigned hold_off_len = 0;   // set by the stimulus, consumed by the receiver
  bit          steady       = 1'b0; // suppress sender gaps for a whole phase

  bitmap_stream_blitter_core #(.MAX_SIDE(SIDE_LIMIT)) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pixel_byte_i (pixel_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .screen_x_o   (screen_x),
    .screen_y_o   (screen_y),
    .color_o      (color),
    .draw_o       (draw),
    .last_o       (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Abort on a hung handshake.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result monitor: a request moves when valid is high and stall is low.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.screen_x = screen_x;
      got.screen_y = screen_y;
      got.color    = color;
      got.draw     = draw;
      got.last     = last;
      sb.check_pixel(got);
    end
  end

  // Receiver: random runs of stall and no stall, plus a long hold-off on demand.
  initial begin
    int unsigned run_left;
    int unsigned hold;
    int unsigned pick;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_len != 0) begin
        hold = hold_off_len;
        hold_off_len = 0;
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        run_left = 0;
      end else if (run_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          out_stall <= 1'b0;
          run_left = $urandom_range(1, 40) - 1;
        end else if (pick < 92) begin
          out_stall <= 1'b1;
          run_left = $urandom_range(1, 3) - 1;
        end else begin
          out_stall <= 1'b1;
          run_left = $urandom_range(8, 30) - 1;
        end
      end else begin
        run_left--;
      end
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte, hold it until accepted, then idle for a random gap.
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    pixel_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid, wait for every owed pixel, then idle before the next step.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic write_all(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                           logic [CFG_DATA_W-1:0] dx, logic [CFG_DATA_W-1:0] dy,
                           pixel_fmt_e fmt, logic transp);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_DEST_X, dx);
    write_reg(CFG_DEST_Y, dy);
    write_reg(CFG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
    write_reg(CFG_TRANSP_EN, CFG_DATA_W'(transp));
    settings++;
  endtask

  // Well-formed pixel bytes for the current format, with row padding in BGR mode.
  // Content favors black, zero alpha and white so transparency gets exercised.
  task automatic stream_pixels(int unsigned npix);
    int unsigned w;
    int unsigned bpp;
    int unsigned pad;
    int unsigned col;
    int unsigned mode;
    logic [7:0]  b;
    w   = blit_scoreboard::side_of(sb.cfg.frame_width);
    bpp = (sb.cfg.pixel_format == FMT_BGRA32) ? 4 : 3;
    pad = (sb.cfg.pixel_format == FMT_BGRA32) ? 0 : (w & 3);
    col = 0;
    repeat (npix) begin
      mode = $urandom_range(0, 9);
      for (int k = 0; k < bpp; k++) begin
        case (mode)
          0, 1:    b = (k == 3) ? 8'($urandom) : 8'h00;
          2:       b = (k == 3) ? 8'h00 : 8'($urandom);
          3:       b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        send_byte(b);
      end
      col++;
      if (col == w) begin
        col = 0;
        repeat (pad) send_byte(8'($urandom));
      end
    end
  endtask

  // Random register setting: mostly small images, now and then zero sides or sides at or above the maximum.
  task automatic pick_setting();
    int unsigned sel;
    logic [CFG_DATA_W-1:0] val;
    for (int r = 0; r < 6; r++) begin
      if ($urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 9);
        case (cfg_idx_e'(r))
          CFG_FRAME_WIDTH:
            val = (sel == 0) ? '0 : (sel == 1) ? CFG_DATA_W'($urandom_range(4096, 8191))
                                               : CFG_DATA_W'($urandom_range(1, 6));
          CFG_FRAME_HEIGHT:
            val = (sel == 0) ? '0 : (sel == 1) ? CFG_DATA_W'($urandom_range(4096, 8191))
                                               : CFG_DATA_W'($urandom_range(1, 4));
          CFG_DEST_X, CFG_DEST_Y:
            val = CFG_DATA_W'($urandom_range(0, 8191));
          default:
            val = CFG_DATA_W'($urandom_range(0, 1));
        endcase
        write_reg(CFG_IDX_W'(r), val);
      end
    end
    if ($urandom_range(0, 9) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                CFG_DATA_W'($urandom_range(0, 8191)));
    settings++;
  endtask

  task automatic random_phase();
    int unsigned w;
    int unsigned h;
    settle();
    pick_setting();
    steady = ($urandom_range(0, 3) == 0);
    w = blit_scoreboard::side_of(sb.cfg.frame_width);
    h = blit_scoreboard::side_of(sb.cfg.frame_height);
    if ($urandom_range(0, 99) < 15) begin
      // broken sequence: leaves the unpacker mid-pixel or mid-row for the next setting
      repeat ($urandom_range(1, 11)) send_byte(8'($urandom));
    end else if (w > 16) begin
      stream_pixels($urandom_range(4, 12));
    end else begin
      stream_pixels(w * $urandom_range(1, ((h < 4) ? h : 4) + 1));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settle();

    // Reset setting: 1x1 BGR, no transparency; black pixel still drawn, one pad byte.
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    settle();

    // Far corner, transparency on: black pixel hidden, white drawn, two pad bytes.
    write_all(13'd2, 13'd1, 13'h1FFF, 13'd4095, FMT_BGR24, 1'b1);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
    settle();

    // Zero sides read as one; alpha zero hidden, black with alpha drawn.
    write_reg(CFG_PIXEL_FORMAT, CFG_DATA_W'(FMT_BGRA32));
    write_reg(CFG_FRAME_WIDTH, '0);
    write_reg(CFG_FRAME_HEIGHT, '0);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h80);

    // Switch to BGR with three bytes gathered: the fourth byte completes the pixel.
    send_byte(8'hAA);
    send_byte(8'hBB);
    send_byte(8'hCC);
    settle();
    write_reg(CFG_PIXEL_FORMAT, CFG_DATA_W'(FMT_BGR24));
    send_byte(8'hDD);
    settle();

    // Pad byte left over from BGR is still skipped in BGRA mode.
    write_reg(CFG_PIXEL_FORMAT, CFG_DATA_W'(FMT_BGRA32));
    send_byte(8'h77);
    settle();

    // Writes past the register list must not disturb anything.
    write_reg(CFG_SPARE_LO, 13'h1FFF);
    write_reg(CFG_SPARE_HI, 13'h1FFF);
    settings++;

    // Oversize sides clamp to the maximum; a few pixels of a huge image only.
    settle();
    write_all(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'd0, FMT_BGRA32, 1'b1);
    stream_pixels(6);

    // Backpressure: hold the receiver off while the sender keeps offering requests.
    settle();
    write_all(13'd3, 13'd8, 13'd100, 13'd50, FMT_BGR24, 1'b0);
    steady = 1'b1;
    hold_off_len = 150;
    stream_pixels(15);
    steady = 1'b0;

    // Shrink the height below the current row near the top edge: screen_y wraps,
    // row ends the image.
    settle();
    write_reg(CFG_DEST_Y, 13'd1);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    stream_pixels(3);

    while (bytes_sent < BYTE_BUDGET) random_phase();

    settle();
    repeat (10) @(posedge clk);
    $display("Streamed %0d pixel bytes under %0d register settings; %0d pixels compared.",
             bytes_sent, settings, sb.n_checked);
    $display("Pixels marked transparent: %0d; image-end pixels: %0d.",
             sb.n_hidden, sb.n_last);
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bsb_pkg.sv
src/bsb_unpack.sv
src/bsb_out_buf.sv
src/bitmap_stream_blitter_core.sv
src/bsb_checker.sv
test/tb_bitmap_stream_blitter_core.sv
